// ----- rtl/core/cwm_pkg.sv -----
// cwm_pkg: sizes, codes, transaction structs and controller types for the
// completion wait matcher. No dependencies; used by every file in rtl/core.

package cwm_pkg;

    // table and field sizes
    localparam int SLOTS       = 8;
    localparam int KEY_BITS    = 16;
    localparam int WAITER_BITS = 8;

    // action codes
    localparam logic ACT_WAIT = 1'b0;
    localparam logic ACT_DONE = 1'b1;

    // wake cause codes
    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_MATCH = 2'd1,
        CAUSE_FULL  = 2'd2
    } t_cause;

    // input transaction
    typedef struct packed {
        logic                   action;
        logic [KEY_BITS-1:0]    key;
        logic [WAITER_BITS-1:0] waiter_id;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic                   wake;
        logic [KEY_BITS-1:0]    wake_key;
        logic [WAITER_BITS-1:0] wake_waiter;
        t_cause                 wake_cause;
        logic                   completion_dropped;
    } t_out_item;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cwm_cmd;

endpackage

// ----- rtl/core/completion_wait_matcher_top.sv -----
// completion_wait_matcher_top: top level joining controller and datapath.
// Depends on cwm_pkg, cwm_ctrl and cwm_datapath.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------
//  input    | in        | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  result   | out       | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// Each item is first latched, then its key is compared against all slots of
// both tables in parallel and the tables and result are written.
// One result per item; the result register lets the next item be latched
// while the previous result is still held under stall.
// Reset is synchronous and empties both key tables in the same cycle.

module completion_wait_matcher_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cwm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cwm_pkg::t_out_item o_out_item
);

    cwm_pkg::t_cwm_cmd cmd;

    // sequencing
    cwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // tables and result
    cwm_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

// ----- rtl/core/cwm_datapath.sv -----
// cwm_datapath: item latch, wait and done key tables, slot compare logic and
// the result register. Depends on cwm_pkg.

module cwm_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cwm_pkg::t_cwm_cmd  i_cmd,
    input  cwm_pkg::t_in_item  i_in_item,
    output cwm_pkg::t_out_item o_out_item
);

    localparam int SLOTS = cwm_pkg::SLOTS;

    cwm_pkg::t_in_item                    r_item;
    cwm_pkg::t_out_item                   r_out;
    cwm_pkg::t_out_item                   n_out;
    logic [cwm_pkg::KEY_BITS-1:0]         r_wait_key   [SLOTS];
    logic [cwm_pkg::WAITER_BITS-1:0]      r_wait_owner [SLOTS];
    logic [cwm_pkg::KEY_BITS-1:0]         r_done_key   [SLOTS];

    logic [SLOTS-1:0] wait_free;
    logic [SLOTS-1:0] wait_sel;
    logic [SLOTS-1:0] wait_hit;
    logic [SLOTS-1:0] wait_hit_sel;
    logic [SLOTS-1:0] done_free;
    logic [SLOTS-1:0] done_sel;
    logic [SLOTS-1:0] done_hit;
    logic [cwm_pkg::WAITER_BITS-1:0] hit_owner;

    // table updates decided this cycle
    logic [SLOTS-1:0] wait_store;
    logic [SLOTS-1:0] wait_clear;
    logic [SLOTS-1:0] done_store;
    logic [SLOTS-1:0] done_clear;

    // parallel slot compares against the latched key
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            wait_free[i] = (r_wait_key[i] == '0);
            done_free[i] = (r_done_key[i] == '0);
            wait_hit[i]  = (r_wait_key[i] == r_item.key);
            done_hit[i]  = (r_done_key[i] == r_item.key);
        end
    end

    // lowest set bit of each vector
    assign wait_sel     = wait_free & (~wait_free + SLOTS'(1));
    assign done_sel     = done_free & (~done_free + SLOTS'(1));
    assign wait_hit_sel = wait_hit & (~wait_hit + SLOTS'(1));

    // owner of the lowest waiting slot with this key
    always_comb begin
        hit_owner = '0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_owner = hit_owner | (r_wait_owner[i] & {cwm_pkg::WAITER_BITS{wait_hit_sel[i]}});
        end
    end

    // decide result and table changes
    // a stored wait key never equals a stored done key between items, so a new
    // item can only pair with entries holding its own key
    always_comb begin
        n_out      = '0;
        wait_store = '0;
        wait_clear = '0;
        done_store = '0;
        done_clear = '0;
        if (r_item.key != '0) begin
            if (r_item.action == cwm_pkg::ACT_WAIT) begin
                if (wait_free == '0) begin
                    n_out.wake        = 1'b1;
                    n_out.wake_key    = r_item.key;
                    n_out.wake_waiter = r_item.waiter_id;
                    n_out.wake_cause  = cwm_pkg::CAUSE_FULL;
                end else if (done_hit != '0) begin
                    // completion already here: pair at once, wait never lands
                    n_out.wake        = 1'b1;
                    n_out.wake_key    = r_item.key;
                    n_out.wake_waiter = r_item.waiter_id;
                    n_out.wake_cause  = cwm_pkg::CAUSE_MATCH;
                    done_clear        = done_hit;
                end else begin
                    wait_store = wait_sel;
                end
            end else begin
                if (done_hit != '0) begin
                    // duplicate completion: nothing stored, nothing to pair
                    n_out = '0;
                end else if (done_free == '0) begin
                    n_out.completion_dropped = 1'b1;
                end else if (wait_hit != '0) begin
                    n_out.wake        = 1'b1;
                    n_out.wake_key    = r_item.key;
                    n_out.wake_waiter = hit_owner;
                    n_out.wake_cause  = cwm_pkg::CAUSE_MATCH;
                    wait_clear        = wait_hit_sel;
                end else begin
                    done_store = done_sel;
                end
            end
        end
    end

    // item latch and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // key tables, emptied by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_wait_key[i] <= '0;
                r_done_key[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (wait_store[i]) begin
                    r_wait_key[i] <= r_item.key;
                end else if (wait_clear[i]) begin
                    r_wait_key[i] <= '0;
                end
                if (done_store[i]) begin
                    r_done_key[i] <= r_item.key;
                end else if (done_clear[i]) begin
                    r_done_key[i] <= '0;
                end
            end
        end
    end

    // owner table, read only from occupied slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (wait_store[i]) begin
                    r_wait_owner[i] <= r_item.waiter_id;
                end
            end
        end
    end

    assign o_out_item = r_out;

endmodule

// ----- rtl/core/cwm_ctrl.sv -----
// cwm_ctrl: state machine sequencing capture and evaluation, plus the result
// valid flag. Depends on cwm_pkg.

module cwm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cwm_pkg::t_cwm_cmd o_cmd
);

    cwm_pkg::t_state r_state;
    cwm_pkg::t_state n_state;
    logic            r_out_vld;
    logic            n_out_vld;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cwm_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_vld   = r_out_vld && i_out_stall;
        case (r_state)
            cwm_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = cwm_pkg::ST_EVAL;
                end
            end
            cwm_pkg::ST_EVAL: begin
                // load result once the output register is free or draining
                if (!r_out_vld || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = cwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cwm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;

endmodule

// ----- rtl/core/cwm_checker.sv -----
// cwm_checker: port-level assertions for the completion wait matcher, bound
// to the top level. Depends on cwm_pkg.

module cwm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cwm_pkg::t_out_item o_out_item
);

    // a held result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // an accepted transaction blocks the input while it is being evaluated
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken during evaluation");

    // no wake means empty wake fields
    a_no_wake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.wake) |->
        (o_out_item.wake_key == '0 && o_out_item.wake_waiter == '0 &&
         o_out_item.wake_cause == cwm_pkg::CAUSE_NONE))
        else $error("wake fields set without wake");

    // a wake carries a real key and cause
    a_wake_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.wake) |->
        (o_out_item.wake_key != '0 &&
         (o_out_item.wake_cause == cwm_pkg::CAUSE_MATCH ||
          o_out_item.wake_cause == cwm_pkg::CAUSE_FULL)))
        else $error("wake with bad key or cause");

    // a dropped completion never wakes anyone
    a_drop_no_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.completion_dropped) |-> !o_out_item.wake)
        else $error("dropped completion woke a waiter");

endmodule

bind completion_wait_matcher_top cwm_checker u_cwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
